>>> rtl/deadline_fifo_job_scheduler_core_assert.svh
// Assertion macros for the deadline FIFO job scheduler.
// Used by the top level; depends on nothing else.
`ifndef DEADLINE_FIFO_JOB_SCHEDULER_CORE_ASSERT_SVH
`define DEADLINE_FIFO_JOB_SCHEDULER_CORE_ASSERT_SVH

// Same-cycle implication, disabled during reset
`define DFJS_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error("dfjs same-cycle check failed");

// Next-cycle implication, disabled during reset
`define DFJS_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error("dfjs next-cycle check failed");

`endif

>>> rtl/dfjs_pkg.sv
// Shared types and constants of the deadline FIFO job scheduler.
// Used by every module of the block; depends on nothing.
`default_nettype none

package dfjs_pkg;

    localparam int QUEUE_DEPTH_DEF = 3;

    localparam int ID_W   = 16;
    localparam int TIME_W = 21;
    localparam int LEN_W  = 16;
    localparam int CODE_W = 2;

    localparam int S_TDATA_W = 80;
    localparam int M_TDATA_W = 64;

    typedef enum logic [CODE_W-1:0] {
        OUT_DONE    = 2'd0,
        OUT_FULL    = 2'd1,
        OUT_LATE    = 2'd2,
        OUT_OVERRUN = 2'd3
    } outcome_t;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CHECK,
        ST_SERVE,
        ST_ADMIT
    } state_t;

    // One queued job as stored in the slot memory
    typedef struct packed {
        logic [ID_W-1:0]   id;
        logic [TIME_W-1:0] arrival;
        logic [LEN_W-1:0]  length;
        logic [TIME_W-1:0] deadline;
    } slot_t;

    // Verdict on the head job
    typedef struct packed {
        outcome_t          outcome;
        logic [TIME_W-1:0] event_time;
        logic [TIME_W-1:0] wait_delay;
        logic [TIME_W-1:0] clock_next;
    } serve_t;

endpackage

`default_nettype wire

>>> rtl/dfjs_slot_ram.sv
// Slot memory of the job queue: one write port, one registered read port.
// Depends on dfjs_pkg for the slot type.
`default_nettype none

module dfjs_slot_ram #(
    parameter int DEPTH = dfjs_pkg::QUEUE_DEPTH_DEF,
    parameter int IDX_W = 2
) (
    input  wire logic               aclk,
    input  wire logic               wr_en,
    input  wire logic [IDX_W-1:0]   wr_addr,
    input  wire dfjs_pkg::slot_t    wr_data,
    input  wire logic               rd_en,
    input  wire logic [IDX_W-1:0]   rd_addr,
    output dfjs_pkg::slot_t         rd_data
);

    dfjs_pkg::slot_t mem [DEPTH];
    dfjs_pkg::slot_t rd_data_reg;

    // Write the tail entry
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Read the head entry, data valid in the cycle after the read
    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

`default_nettype wire

>>> rtl/dfjs_serve_unit.sv
// Evaluates the head job against the simulated clock: done, late or overrun.
// Depends on dfjs_pkg for the slot and verdict types.
`default_nettype none

module dfjs_serve_unit (
    input  wire logic [dfjs_pkg::TIME_W-1:0] clock_now,
    input  wire dfjs_pkg::slot_t             job,
    output dfjs_pkg::serve_t                 verdict
);

    logic [dfjs_pkg::TIME_W-1:0] start_at;
    logic [dfjs_pkg::TIME_W:0]   finish_time;
    logic                        is_late;
    logic                        fits;

    // Start at the later of clock and arrival; finish at full width
    always_comb begin
        is_late     = (clock_now >= job.deadline);
        start_at    = (clock_now > job.arrival) ? clock_now : job.arrival;
        finish_time = {1'b0, start_at} + {{(dfjs_pkg::TIME_W + 1 - dfjs_pkg::LEN_W){1'b0}},
                                          job.length};
        fits        = (finish_time <= {1'b0, job.deadline});
    end

    // Pick outcome, event time, delay and the new clock
    always_comb begin
        if (is_late) begin
            verdict.outcome    = dfjs_pkg::OUT_LATE;
            verdict.event_time = clock_now;
            verdict.wait_delay = (clock_now >= job.arrival) ? clock_now - job.arrival
                                                            : '0;
            verdict.clock_next = clock_now;
        end else if (fits) begin
            verdict.outcome    = dfjs_pkg::OUT_DONE;
            verdict.event_time = finish_time[dfjs_pkg::TIME_W-1:0];
            verdict.wait_delay = start_at - job.arrival;
            verdict.clock_next = finish_time[dfjs_pkg::TIME_W-1:0];
        end else begin
            verdict.outcome    = dfjs_pkg::OUT_OVERRUN;
            verdict.event_time = job.deadline;
            verdict.wait_delay = (job.deadline >= job.arrival) ? job.deadline - job.arrival
                                                               : '0;
            verdict.clock_next = job.deadline;
        end
    end

endmodule

`default_nettype wire

>>> rtl/deadline_fifo_job_scheduler_core.sv
// Deadline FIFO job scheduler: sequencer, clock and queue pointers, result register.
// An item with no results passes IDLE, CHECK and ADMIT before the input is free again;
// each served job adds a slot memory read (CHECK), then an evaluation (SERVE), and
// a final job drains the queue before the input is free again; a result register
// that is still full stalls the sequencer for as long as the result is not taken.
// A result appears on m_ in the cycle after it is evaluated and is held until taken.
// Reset (aresetn low, synchronous) clears clock, head, fill, state and result valid.
`default_nettype none

`include "deadline_fifo_job_scheduler_core_assert.svh"

module deadline_fifo_job_scheduler_core #(
    parameter int QUEUE_DEPTH = dfjs_pkg::QUEUE_DEPTH_DEF
) (
    input  wire logic                              aclk,
    input  wire logic                              aresetn,
    // job_id[15:0], arrival_time[36:16], run_length[52:37], deadline[73:53]
    input  wire logic [dfjs_pkg::S_TDATA_W-1:0]    s_tdata,
    input  wire logic                              s_tlast,
    input  wire logic                              s_tvalid,
    output logic                                   s_tready,
    // result_id[15:0], event_time[36:16], wait_delay[57:37]
    output logic [dfjs_pkg::M_TDATA_W-1:0]         m_tdata,
    // outcome[1:0]
    output logic [dfjs_pkg::CODE_W-1:0]            m_tuser,
    output logic                                   m_tlast,
    output logic                                   m_tvalid,
    input  wire logic                              m_tready
);

    localparam int IDX_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;
    localparam int TW    = dfjs_pkg::TIME_W;

    // Control state
    dfjs_pkg::state_t   state_reg, state_next;
    logic [TW-1:0]      clock_reg, clock_next;
    logic [IDX_W-1:0]   head_reg, head_next;
    logic [CNT_W-1:0]   fill_reg, fill_next;
    logic               drain_reg, drain_next;

    // Current job
    dfjs_pkg::slot_t    job_reg, job_next;
    logic               final_reg, final_next;

    // Result register
    logic               out_valid_reg, out_valid_next;
    logic               out_last_reg, out_last_next;
    dfjs_pkg::outcome_t out_code_reg, out_code_next;
    logic [dfjs_pkg::ID_W-1:0] out_id_reg, out_id_next;
    logic [TW-1:0]      out_time_reg, out_time_next;
    logic [TW-1:0]      out_delay_reg, out_delay_next;

    // Memory and serve unit
    logic               rd_en, wr_en;
    logic [IDX_W-1:0]   tail_idx;
    logic [SUM_W-1:0]   tail_sum;
    dfjs_pkg::slot_t    head_job;
    dfjs_pkg::serve_t   verdict;
    logic               out_free;
    logic               serve_fire;
    logic [CNT_W-1:0]   fill_dec;
    logic               s_accept;

    assign s_accept = s_tvalid && s_tready;
    assign out_free = !out_valid_reg || m_tready;

    // Tail slot: (head + fill) modulo depth, the sum stays below twice the depth
    always_comb begin
        tail_sum = SUM_W'(head_reg) + SUM_W'(fill_reg);
        if (tail_sum >= SUM_W'(QUEUE_DEPTH)) begin
            tail_sum = tail_sum - SUM_W'(QUEUE_DEPTH);
        end
        tail_idx = tail_sum[IDX_W-1:0];
    end

    dfjs_slot_ram #(
        .DEPTH (QUEUE_DEPTH),
        .IDX_W (IDX_W)
    ) u_slot_ram (
        .aclk    (aclk),
        .wr_en   (wr_en),
        .wr_addr (tail_idx),
        .wr_data (job_reg),
        .rd_en   (rd_en),
        .rd_addr (head_reg),
        .rd_data (head_job)
    );

    dfjs_serve_unit u_serve_unit (
        .clock_now (clock_reg),
        .job       (head_job),
        .verdict   (verdict)
    );

    assign fill_dec = fill_reg - CNT_W'(1);

    // Sequencer: next state, queue pointers, clock and result load
    always_comb begin
        state_next     = state_reg;
        clock_next     = clock_reg;
        head_next      = head_reg;
        fill_next      = fill_reg;
        drain_next     = drain_reg;
        job_next       = job_reg;
        final_next     = final_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_last_next  = out_last_reg;
        out_code_next  = out_code_reg;
        out_id_next    = out_id_reg;
        out_time_next  = out_time_reg;
        out_delay_next = out_delay_reg;
        rd_en          = 1'b0;
        wr_en          = 1'b0;
        serve_fire     = 1'b0;
        s_tready       = 1'b0;

        case (state_reg)
            dfjs_pkg::ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    job_next.id       = s_tdata[15:0];
                    job_next.arrival  = s_tdata[36:16];
                    job_next.length   = s_tdata[52:37];
                    job_next.deadline = s_tdata[73:53];
                    final_next        = s_tlast;
                    state_next        = dfjs_pkg::ST_CHECK;
                end
            end

            dfjs_pkg::ST_CHECK: begin
                // Serve while the queue is not empty and the clock lags the arrival, or while draining
                if (fill_reg != '0 && (drain_reg || clock_reg < job_reg.arrival)) begin
                    rd_en      = 1'b1;
                    state_next = dfjs_pkg::ST_SERVE;
                end else if (drain_reg) begin
                    drain_next = 1'b0;
                    state_next = dfjs_pkg::ST_IDLE;
                end else begin
                    state_next = dfjs_pkg::ST_ADMIT;
                end
            end

            dfjs_pkg::ST_SERVE: begin
                if (out_free) begin
                    serve_fire     = 1'b1;
                    clock_next     = verdict.clock_next;
                    head_next      = (head_reg == IDX_W'(QUEUE_DEPTH - 1)) ? '0
                                                                          : head_reg + IDX_W'(1);
                    fill_next      = fill_dec;
                    out_valid_next = 1'b1;
                    out_code_next  = verdict.outcome;
                    out_id_next    = head_job.id;
                    out_time_next  = verdict.event_time;
                    out_delay_next = verdict.wait_delay;
                    if (drain_reg) begin
                        out_last_next = (fill_dec == '0);
                        if (fill_dec == '0) begin
                            drain_next = 1'b0;
                            state_next = dfjs_pkg::ST_IDLE;
                        end else begin
                            state_next = dfjs_pkg::ST_CHECK;
                        end
                    end else begin
                        // Last only if serving stops here and no drain follows
                        out_last_next = (fill_dec == '0 ||
                                         verdict.clock_next >= job_reg.arrival) && !final_reg;
                        state_next    = dfjs_pkg::ST_CHECK;
                    end
                end
            end

            dfjs_pkg::ST_ADMIT: begin
                if (fill_reg < CNT_W'(QUEUE_DEPTH)) begin
                    wr_en      = 1'b1;
                    fill_next  = fill_reg + CNT_W'(1);
                    if (clock_reg < job_reg.arrival) begin
                        clock_next = job_reg.arrival;
                    end
                    drain_next = final_reg;
                    state_next = final_reg ? dfjs_pkg::ST_CHECK : dfjs_pkg::ST_IDLE;
                end else if (out_free) begin
                    // Queue full: reject the arriving job at once
                    out_valid_next = 1'b1;
                    out_code_next  = dfjs_pkg::OUT_FULL;
                    out_id_next    = job_reg.id;
                    out_time_next  = job_reg.arrival;
                    out_delay_next = '0;
                    out_last_next  = !final_reg;
                    drain_next     = final_reg;
                    state_next     = final_reg ? dfjs_pkg::ST_CHECK : dfjs_pkg::ST_IDLE;
                end
            end

            default: begin
                state_next = dfjs_pkg::ST_IDLE;
            end
        endcase
    end

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= dfjs_pkg::ST_IDLE;
            clock_reg     <= '0;
            head_reg      <= '0;
            fill_reg      <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            clock_reg     <= clock_next;
            head_reg      <= head_next;
            fill_reg      <= fill_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        job_reg       <= job_next;
        final_reg     <= final_next;
        out_last_reg  <= out_last_next;
        out_code_reg  <= out_code_next;
        out_id_reg    <= out_id_next;
        out_time_reg  <= out_time_next;
        out_delay_reg <= out_delay_next;
    end

    // Drive the result channel
    assign m_tvalid = out_valid_reg;
    assign m_tlast  = out_last_reg;
    assign m_tuser  = out_code_reg;
    assign m_tdata  = {6'd0, out_delay_reg, out_time_reg, out_id_reg};

    `DFJS_ASSERT_NOW(a_fill_bound, aclk, aresetn, 1'b1, fill_reg <= CNT_W'(QUEUE_DEPTH))
    `DFJS_ASSERT_NEXT(a_serve_pops, aclk, aresetn, serve_fire, fill_reg == $past(fill_dec))
    `DFJS_ASSERT_NOW(a_idle_no_drain, aclk, aresetn, state_reg == dfjs_pkg::ST_IDLE, !drain_reg)
    `DFJS_ASSERT_NEXT(a_accept_checks, aclk, aresetn, s_accept, state_reg == dfjs_pkg::ST_CHECK)

endmodule

`default_nettype wire
